// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion failed");
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_NEVER(label, clk, rst_n, cond)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== hdl/srld_pkg.sv =====
// Types and constants for the sprite run-length decoder.
// No dependencies; used by every module of the block.
`default_nettype none
package srld_pkg;

    localparam int WORD_W     = 16;
    localparam int RUN_W      = 15;
    localparam int LINE_W     = 16;
    localparam int QUEUE_AW   = 2;
    localparam int QUEUE_DEPTH = 1 << QUEUE_AW;
    localparam int QUEUE_CW   = QUEUE_AW + 1;
    localparam int TDATA_W    = 48;

    typedef enum logic [1:0] {
        PH_TAG  = 2'd0,
        PH_LIT  = 2'd1,
        PH_END  = 2'd2,
        PH_DONE = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        KIND_PIXEL = 2'd0,
        KIND_RUN   = 2'd1,
        KIND_LINE  = 2'd2,
        KIND_IMAGE = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [WORD_W-1:0]  pixel_value;
        logic [RUN_W-1:0]   run_length;
        logic [LINE_W-1:0]  line_number;
    } result_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

endpackage
`default_nettype wire

// ===== hdl/srld_front.sv =====
// Front end: accepts stream words, tracks the line state and classifies each word.
// Depends on srld_pkg; pushes results into srld_queue.
`default_nettype none
module srld_front (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_we,
    input  wire logic [srld_pkg::LINE_W-1:0] cfg_wdata,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [srld_pkg::WORD_W-1:0] s_tdata,
    input  wire logic                        s_tuser,
    input  srld_pkg::qstat_t                 q_stat,
    output logic                             q_push,
    output srld_pkg::result_t                q_data
);
    import srld_pkg::*;

    phase_t              phase_reg, phase_next;
    logic [RUN_W-1:0]    lit_reg, lit_next;
    logic [LINE_W-1:0]   line_reg, line_next;
    logic [LINE_W-1:0]   height_reg;

    phase_t              eff_phase;
    logic [RUN_W-1:0]    eff_lit;
    logic [LINE_W-1:0]   eff_line;
    logic [LINE_W:0]     line_inc;
    logic                accept;
    logic                produce;

    assign s_tready = !q_stat.full;
    assign accept   = s_tvalid && s_tready;
    assign q_push   = accept && produce;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_TAG;
            lit_reg    <= '0;
            line_reg   <= '0;
            height_reg <= LINE_W'(1);
        end else begin
            if (cfg_we) begin
                height_reg <= cfg_wdata;
            end
            if (accept) begin
                phase_reg <= phase_next;
                lit_reg   <= lit_next;
                line_reg  <= line_next;
            end
        end
    end

    always_comb begin
        eff_phase = s_tuser ? PH_TAG : phase_reg;
        eff_lit   = s_tuser ? '0 : lit_reg;
        eff_line  = s_tuser ? '0 : line_reg;
        line_inc  = {1'b0, eff_line} + (LINE_W+1)'(1);

        phase_next = eff_phase;
        lit_next   = eff_lit;
        line_next  = eff_line;
        produce    = 1'b0;
        q_data.kind        = KIND_PIXEL;
        q_data.pixel_value = '0;
        q_data.run_length  = '0;
        q_data.line_number = eff_line;

        case (eff_phase)
            PH_TAG: begin
                if (s_tdata == '0) begin
                    produce     = 1'b1;
                    q_data.kind = KIND_LINE;
                    line_next   = line_inc[LINE_W-1:0];
                    if (line_inc >= {1'b0, height_reg}) begin
                        phase_next = PH_END;
                    end
                end else if (s_tdata[0]) begin
                    lit_next   = s_tdata[WORD_W-1:1];
                    phase_next = (s_tdata[WORD_W-1:1] != '0) ? PH_LIT : PH_TAG;
                end else begin
                    produce           = 1'b1;
                    q_data.kind       = KIND_RUN;
                    q_data.run_length = s_tdata[WORD_W-1:1];
                end
            end
            PH_LIT: begin
                produce            = 1'b1;
                q_data.kind        = KIND_PIXEL;
                q_data.pixel_value = s_tdata;
                lit_next           = eff_lit - RUN_W'(1);
                phase_next         = (lit_next == '0) ? PH_TAG : PH_LIT;
            end
            PH_END: begin
                produce     = 1'b1;
                q_data.kind = KIND_IMAGE;
                phase_next  = PH_DONE;
            end
            default: begin
                phase_next = PH_DONE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== hdl/srld_queue.sv =====
// Short result queue between the front end and the output stage.
// Depends on srld_pkg.
`default_nettype none
module srld_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  srld_pkg::result_t  push_data,
    input  wire logic          pop,
    output srld_pkg::result_t  pop_data,
    output srld_pkg::qstat_t   stat
);
    import srld_pkg::*;

    result_t               mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg;
    logic [QUEUE_AW-1:0]   rd_ptr_reg;
    logic [QUEUE_CW-1:0]   count_reg;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_AW'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + QUEUE_CW'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - QUEUE_CW'(1);
            end
        end
    end

    assign pop_data   = mem[rd_ptr_reg];
    assign stat.full  = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);

endmodule
`default_nettype wire

// ===== hdl/srld_back.sv =====
// Back end: output register that drains the queue onto the result stream.
// Depends on srld_pkg; reads from srld_queue.
`default_nettype none
module srld_back (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  srld_pkg::qstat_t                  q_stat,
    input  srld_pkg::result_t                 q_data,
    output logic                              q_pop,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [srld_pkg::TDATA_W-1:0]      m_tdata,
    output logic [1:0]                        m_tuser
);
    import srld_pkg::*;

    logic     valid_reg;
    result_t  data_reg;

    assign q_pop = !q_stat.empty && (!valid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (!valid_reg || m_tready) begin
            valid_reg <= !q_stat.empty;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            data_reg <= q_data;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {1'b0, data_reg.line_number, data_reg.run_length, data_reg.pixel_value};
    assign m_tuser  = data_reg.kind;

endmodule
`default_nettype wire

// ===== hdl/sprite_run_length_decoder_top.sv =====
// Top level of the sprite run-length decoder: front end, result queue, output stage.
// Depends on srld_pkg, srld_front, srld_queue, srld_back and assert_macros.svh.
//
//  channel | dir | bits                                           | tuser
//  s_      | in  | tdata[15:0] word                               | [0] start_of_image
//  m_      | out | tdata[15:0] pixel, [30:16] run, [46:31] line   | [1:0] kind
//  cfg     | in  | cfg_wdata[15:0] image_height, taken when cfg_we | -
//
// One word per cycle in while s_tready is high, at most one result per word out;
// each result is written into the queue, then into the output register.
// The four-entry queue lets the input keep running while the output stalls;
// s_tready drops only when the queue is full.
// Synchronous active-low reset; image_height resets to one.
`default_nettype none
`include "assert_macros.svh"
module sprite_run_length_decoder_top (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_we,
    input  wire logic [srld_pkg::LINE_W-1:0]  cfg_wdata,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [srld_pkg::WORD_W-1:0]  s_tdata,   // [15:0] word
    input  wire logic                         s_tuser,   // [0] start_of_image
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [srld_pkg::TDATA_W-1:0]      m_tdata,   // pixel_value, run_length, line_number
    output logic [1:0]                        m_tuser    // [1:0] kind
);
    import srld_pkg::*;

    qstat_t   q_stat;
    logic     q_push;
    logic     q_pop;
    result_t  q_wdata;
    result_t  q_rdata;

    srld_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_stat    (q_stat),
        .q_push    (q_push),
        .q_data    (q_wdata)
    );

    srld_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_wdata),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .stat      (q_stat)
    );

    srld_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_stat   (q_stat),
        .q_data   (q_rdata),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    `ASSERT_IMPLIES(a_no_overflow, aclk, aresetn, q_push, !q_stat.full)
    `ASSERT_IMPLIES(a_no_underflow, aclk, aresetn, q_pop, !q_stat.empty)
    `ASSERT_IMPLIES(a_pixel_only_literal, aclk, aresetn, m_tvalid && (m_tuser != KIND_PIXEL), m_tdata[15:0] == 16'd0)
    `ASSERT_IMPLIES(a_run_only_run, aclk, aresetn, m_tvalid && (m_tuser != KIND_RUN), m_tdata[30:16] == 15'd0)

endmodule
`default_nettype wire
